FILE: rtl/pkt_pkg.sv
// shared types, constants and helpers of the port knock tracker
package pkt_pkg;

    // table size default and knock sequence length
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KNOCK_LEN       = 5;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    // register indexes on the configuration port
    localparam logic [2:0] REG_KNOCK_PORT_0 = 3'd0;
    localparam logic [2:0] REG_KNOCK_PORT_1 = 3'd1;
    localparam logic [2:0] REG_KNOCK_PORT_2 = 3'd2;
    localparam logic [2:0] REG_KNOCK_PORT_3 = 3'd3;
    localparam logic [2:0] REG_KNOCK_PORT_4 = 3'd4;
    localparam logic [2:0] REG_KNOCK_TIMEOUT = 3'd5;

    // register reset values
    localparam logic [15:0] KNOCK_PORT_0_RST  = 16'd1111;
    localparam logic [15:0] KNOCK_PORT_1_RST  = 16'd11;
    localparam logic [15:0] KNOCK_PORT_2_RST  = 16'd2222;
    localparam logic [15:0] KNOCK_PORT_3_RST  = 16'd222;
    localparam logic [15:0] KNOCK_PORT_4_RST  = 16'd22;
    localparam logic [15:0] KNOCK_TIMEOUT_RST = 16'd5;

    // outcome codes
    localparam logic [2:0] OUT_ALREADY  = 3'd0;
    localparam logic [2:0] OUT_ADVANCED = 3'd1;
    localparam logic [2:0] OUT_UNLOCKED = 3'd2;
    localparam logic [2:0] OUT_WRONG    = 3'd3;
    localparam logic [2:0] OUT_NEW      = 3'd4;
    localparam logic [2:0] OUT_FULL     = 3'd5;

    typedef logic [15:0] port_t;

    // input word
    typedef struct packed {
        logic [31:0] source_addr;
        logic [15:0] knock_port;
        logic [31:0] now_seconds;
    } in_word_t;

    // output word
    typedef struct packed {
        logic       granted;
        logic [2:0] outcome;
        logic [2:0] progress;
    } out_word_t;

    // configuration register set
    typedef struct packed {
        port_t [KNOCK_LEN-1:0] knock_port;
        logic [15:0]           knock_timeout;
    } cfg_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [31:0] addr;
        logic [2:0]  progress;
        logic [31:0] last_time;
        logic        unlocked;
    } entry_t;

    // update decision handed back to the sequencer
    typedef struct packed {
        logic      we;
        entry_t    wentry;
        out_word_t result;
    } upd_t;

    // expected port at a given sequence position
    function automatic port_t knock_sel(input cfg_t cfg, input logic [2:0] pos);
        port_t p;
        case (pos)
            3'd0:    p = cfg.knock_port[0];
            3'd1:    p = cfg.knock_port[1];
            3'd2:    p = cfg.knock_port[2];
            3'd3:    p = cfg.knock_port[3];
            3'd4:    p = cfg.knock_port[4];
            default: p = cfg.knock_port[0];
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/pkt_ram.sv
// generic single-write, single-read ram with registered read data
module pkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/pkt_cfg.sv
// apb register file for the knock sequence and timeout
module pkt_cfg
    import pkt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.knock_port[0] <= KNOCK_PORT_0_RST;
            cfg_reg.knock_port[1] <= KNOCK_PORT_1_RST;
            cfg_reg.knock_port[2] <= KNOCK_PORT_2_RST;
            cfg_reg.knock_port[3] <= KNOCK_PORT_3_RST;
            cfg_reg.knock_port[4] <= KNOCK_PORT_4_RST;
            cfg_reg.knock_timeout <= KNOCK_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KNOCK_PORT_0:  cfg_reg.knock_port[0] <= pwdata[15:0];
                REG_KNOCK_PORT_1:  cfg_reg.knock_port[1] <= pwdata[15:0];
                REG_KNOCK_PORT_2:  cfg_reg.knock_port[2] <= pwdata[15:0];
                REG_KNOCK_PORT_3:  cfg_reg.knock_port[3] <= pwdata[15:0];
                REG_KNOCK_PORT_4:  cfg_reg.knock_port[4] <= pwdata[15:0];
                REG_KNOCK_TIMEOUT: cfg_reg.knock_timeout <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_KNOCK_PORT_0:  prdata = {16'b0, cfg_reg.knock_port[0]};
            REG_KNOCK_PORT_1:  prdata = {16'b0, cfg_reg.knock_port[1]};
            REG_KNOCK_PORT_2:  prdata = {16'b0, cfg_reg.knock_port[2]};
            REG_KNOCK_PORT_3:  prdata = {16'b0, cfg_reg.knock_port[3]};
            REG_KNOCK_PORT_4:  prdata = {16'b0, cfg_reg.knock_port[4]};
            REG_KNOCK_TIMEOUT: prdata = {16'b0, cfg_reg.knock_timeout};
            default:           prdata = '0;
        endcase
    end

endmodule

FILE: rtl/pkt_step.sv
// entry update: decides the new entry contents and the result word
module pkt_step
    import pkt_pkg::*;
(
    input  cfg_t     cfg,
    input  in_word_t item,
    input  entry_t   entry,
    input  logic     hit,
    input  logic     full,
    output upd_t     upd
);

    logic [31:0] gap;
    logic [2:0]  pos;
    logic [2:0]  pos_inc;
    logic        port_ok;
    logic        first_ok;

    // expected position, restarted on a bad stored value or a timeout
    always_comb
    begin
        gap = item.now_seconds - entry.last_time;
        if (entry.progress >= 3'(KNOCK_LEN))
        begin
            pos = 3'd0;
        end
        else
        begin
            pos = entry.progress;
        end
        if (gap > {16'b0, cfg.knock_timeout})
        begin
            pos = 3'd0;
        end
        pos_inc  = pos + 3'd1;
        port_ok  = (item.knock_port == knock_sel(cfg, pos));
        first_ok = (item.knock_port == cfg.knock_port[0]);
    end

    // update decision
    always_comb
    begin
        upd.we     = 1'b0;
        upd.wentry = entry;
        upd.result = '{granted: 1'b0, outcome: OUT_FULL, progress: 3'd0};
        if (hit)
        begin
            if (entry.unlocked)
            begin
                upd.result = '{granted: 1'b1, outcome: OUT_ALREADY, progress: 3'd0};
            end
            else if (port_ok)
            begin
                upd.we               = 1'b1;
                upd.wentry.last_time = item.now_seconds;
                if (pos_inc == 3'(KNOCK_LEN))
                begin
                    upd.wentry.unlocked = 1'b1;
                    upd.wentry.progress = 3'd0;
                    upd.result = '{granted: 1'b1, outcome: OUT_UNLOCKED, progress: 3'd0};
                end
                else
                begin
                    upd.wentry.progress = pos_inc;
                    upd.result = '{granted: 1'b0, outcome: OUT_ADVANCED, progress: pos_inc};
                end
            end
            else
            begin
                upd.we              = 1'b1;
                upd.wentry.progress = 3'd0;
                upd.result = '{granted: 1'b0, outcome: OUT_WRONG, progress: 3'd0};
            end
        end
        else if (!full)
        begin
            upd.we               = 1'b1;
            upd.wentry.addr      = item.source_addr;
            upd.wentry.progress  = first_ok ? 3'd1 : 3'd0;
            upd.wentry.last_time = item.now_seconds;
            upd.wentry.unlocked  = 1'b0;
            upd.result = '{granted: 1'b0, outcome: OUT_NEW,
                           progress: (first_ok ? 3'd1 : 3'd0)};
        end
    end

endmodule

FILE: rtl/port_knock_tracker_core.sv
// top level: sequencer that scans the address table and applies one update
// Port knock tracker. Each connection attempt word (source address, port,
// seconds) is looked up in a table of up to TABLE_DEPTH addresses held in one
// ram; the scan reads one entry per cycle through the ram's single read port
// and compares it with a single address comparator. A word that matches an
// entry ends the scan there; a new or dropped address is answered only after
// every entry in use has been read. The next word is accepted only once the
// previous one has been applied, and that update is held back while the
// previous result is still in the output register. in_ready is high only
// between words. The table is tracked by a fill count, so no clearing pass
// follows reset. A finished result waits in the output register while the
// next word is taken in. Configuration is written through the apb port only
// while the block is idle; the user must keep to this, the block does not enforce it.
module port_knock_tracker_core
    import pkt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_word_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           entry_reg, entry_next;
    in_word_t         item_reg, item_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    cfg_t             cfg;
    upd_t             upd;
    entry_t           ram_rdata;
    logic [ENT_W-1:0] ram_rdata_raw;
    logic             ram_re;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             addr_match;
    logic             more;
    logic             full;
    logic             upd_fire;
    logic             in_fire;

    // configuration registers
    pkt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // address table
    pkt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (upd.wentry),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    // entry update logic
    pkt_step u_step (
        .cfg   (cfg),
        .item  (item_reg),
        .entry (entry_reg),
        .hit   (hit_reg),
        .full  (full),
        .upd   (upd)
    );

    // handshake and scan control terms
    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign addr_match = pend_reg && (ram_rdata.addr == item_reg.source_addr);
    assign more       = (rd_idx_reg < count_reg);
    assign ram_re     = (state_reg == ST_SCAN) && !addr_match && more;
    assign upd_fire   = (state_reg == ST_UPDATE) && !(out_valid_reg && !out_ready);
    assign ram_we     = upd_fire && upd.we;
    assign ram_waddr  = hit_reg ? hit_idx_reg : count_reg[IDX_W-1:0];

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = pend_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        entry_next   = entry_reg;
        item_next    = item_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next   = in_data;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (addr_match)
                begin
                    entry_next   = ram_rdata;
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = ST_UPDATE;
                end
                else if (more)
                begin
                    cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                end
                else
                begin
                    hit_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    if (!hit_reg && !full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (upd_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = upd.result;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        entry_reg    <= entry_next;
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // fill count never passes the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // fill count grows by at most one per word
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("entry count jumped");

    // table written only while applying an update
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_UPDATE))
        else $error("table write outside update");

    // a new result appears only after an update
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_UPDATE))
        else $error("result without update");

    // reads never go past the filled part of the table
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (rd_idx_reg < count_reg))
        else $error("read of unfilled entry");
`endif

endmodule

FILE: verif/tb_port_knock_tracker_core.sv
`timescale 1ns / 1ps
// self-checking testbench of the port knock tracker core with its own table predictor
module tb_port_knock_tracker_core;
    import pkt_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int POOL_SLICE = 18;
    localparam int POOL_SIZE  = 3 * POOL_SLICE;
    localparam int PHASE_LEN  = 560;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid;
    logic               in_ready;
    in_word_t           in_data;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_word_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // directed stimulus row
    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t want;
    } probe_t;

    // predictor state: knock settings and address table
    cfg_t        knock_cfg;
    logic [31:0] tab_addr [DEPTH];
    logic [2:0]  tab_prog [DEPTH];
    logic [31:0] tab_time [DEPTH];
    logic        tab_open [DEPTH];
    int          tab_fill;

    out_word_t   verdict_q [$];
    probe_t      probes [$];
    logic [31:0] pool [POOL_SIZE];
    logic [31:0] clock_s;
    int          src_idle;
    int          sink_idle;
    int          fault_count = 0;

    port_knock_tracker_core #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // verdict for one connection attempt, updating the table copy
    function automatic out_word_t track_attempt(input in_word_t w);
        out_word_t   r;
        logic [2:0]  pos;
        logic [31:0] gap;
        r = '0;
        for (int i = 0; i < tab_fill; i++)
        begin
            if (tab_addr[i] == w.source_addr)
            begin
                if (tab_open[i])
                begin
                    r.granted = 1'b1;
                    r.outcome = OUT_ALREADY;
                    return r;
                end
                pos = tab_prog[i];
                if (pos >= KNOCK_LEN)
                    pos = 3'd0;
                // stale entry restarts at the first knock
                gap = w.now_seconds - tab_time[i];
                if (gap > {16'd0, knock_cfg.knock_timeout})
                    pos = 3'd0;
                if (w.knock_port == knock_cfg.knock_port[pos])
                begin
                    tab_time[i] = w.now_seconds;
                    if (pos == KNOCK_LEN - 1)
                    begin
                        tab_open[i] = 1'b1;
                        tab_prog[i] = 3'd0;
                        r.granted   = 1'b1;
                        r.outcome   = OUT_UNLOCKED;
                    end
                    else
                    begin
                        tab_prog[i] = pos + 3'd1;
                        r.outcome   = OUT_ADVANCED;
                        r.progress  = pos + 3'd1;
                    end
                end
                else
                begin
                    tab_prog[i] = 3'd0;
                    r.outcome   = OUT_WRONG;
                end
                return r;
            end
        end
        if (tab_fill >= DEPTH)
        begin
            r.outcome = OUT_FULL;
            return r;
        end
        // unknown address takes the next free entry
        tab_addr[tab_fill] = w.source_addr;
        tab_prog[tab_fill] = (w.knock_port == knock_cfg.knock_port[0]) ? 3'd1 : 3'd0;
        tab_time[tab_fill] = w.now_seconds;
        tab_open[tab_fill] = 1'b0;
        r.outcome  = OUT_NEW;
        r.progress = tab_prog[tab_fill];
        tab_fill++;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // result side: compare accepted words, random back-pressure
    always @(posedge clk)
    begin : sink
        out_word_t want;
        if (out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result word with no expectation pending");
                fault_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("granted", {2'b00, want.granted}, {2'b00, out_data.granted});
                check_field("outcome", want.outcome, out_data.outcome);
                check_field("progress", want.progress, out_data.progress);
            end
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= sink_idle);
    end

    // offer one attempt word and log its verdict once accepted
    task automatic send_attempt(input in_word_t w, input logic typed, input out_word_t typed_want);
        out_word_t pred;
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        pred = track_attempt(w);
        verdict_q.push_back(typed ? typed_want : pred);
    endtask

    // hold off the sender until every verdict is back
    task automatic await_verdicts();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    // write all six registers back to back
    task automatic load_settings(input cfg_t c);
        logic [2:0]  idx;
        logic [15:0] val;
        for (int i = 0; i <= KNOCK_LEN; i++)
        begin
            if (i < KNOCK_LEN)
            begin
                idx = REG_KNOCK_PORT_0 + 3'(i);
                val = c.knock_port[i];
            end
            else
            begin
                idx = REG_KNOCK_TIMEOUT;
                val = c.knock_timeout;
            end
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= {16'd0, val};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        knock_cfg = c;
    endtask

    task automatic probe(input logic [31:0] a, input port_t p, input logic [31:0] t);
        probe_t r;
        r = '0;
        r.word = {a, p, t};
        probes.push_back(r);
    endtask

    task automatic probe_want(input logic [31:0] a, input port_t p, input logic [31:0] t,
                              input logic g, input logic [2:0] o, input logic [2:0] pr);
        probe_t r;
        r.word  = {a, p, t};
        r.typed = 1'b1;
        r.want  = {g, o, pr};
        probes.push_back(r);
    endtask

    // mostly knock sequences on a slice of the address pool, the rest noise
    task automatic run_random(input int n_items, input int pool_base, input int fresh_pct);
        in_word_t    w;
        int          sent;
        int          len;
        int          roll;
        int          slot;
        logic        paused;
        logic [31:0] limit;
        sent   = 0;
        paused = 1'b0;
        limit  = {16'd0, knock_cfg.knock_timeout};
        while (sent < n_items)
        begin
            if (!paused && sent >= n_items / 2)
            begin
                await_verdicts();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            w.source_addr = pool[pool_base + $urandom_range(0, POOL_SLICE - 1)];
            if (roll < 75)
            begin
                // start past the timeout so matching begins at the first knock
                len = ($urandom_range(0, 99) < 15) ? KNOCK_LEN : $urandom_range(1, KNOCK_LEN - 1);
                clock_s = clock_s + limit + 1 + $urandom_range(0, 300);
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    if (k > 0)
                    begin
                        case ($urandom_range(0, 9))
                            0, 1, 2: clock_s = clock_s;
                            3, 4:    clock_s = clock_s + limit;
                            5:       clock_s = clock_s + limit + 1 + $urandom_range(0, 40);
                            default: clock_s = clock_s + $urandom_range(0, limit);
                        endcase
                    end
                    if ($urandom_range(0, 99) < 12)
                        w.knock_port = $urandom_range(0, 65535);
                    else
                        w.knock_port = knock_cfg.knock_port[k];
                    w.now_seconds = clock_s;
                    send_attempt(w, 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                if (roll >= 100 - fresh_pct)
                    w.source_addr = $urandom();
                slot = $urandom_range(0, KNOCK_LEN - 1);
                if ($urandom_range(0, 1))
                    w.knock_port = $urandom_range(0, 65535);
                else
                    w.knock_port = knock_cfg.knock_port[slot];
                if ($urandom_range(0, 1))
                    w.now_seconds = $urandom();
                else
                    w.now_seconds = clock_s + $urandom_range(0, limit);
                send_attempt(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        cfg_t c;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        knock_cfg.knock_port[0] = KNOCK_PORT_0_RST;
        knock_cfg.knock_port[1] = KNOCK_PORT_1_RST;
        knock_cfg.knock_port[2] = KNOCK_PORT_2_RST;
        knock_cfg.knock_port[3] = KNOCK_PORT_3_RST;
        knock_cfg.knock_port[4] = KNOCK_PORT_4_RST;
        knock_cfg.knock_timeout = KNOCK_TIMEOUT_RST;
        tab_fill = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = $urandom();
        clock_s   = $urandom();
        src_idle  = 17;
        sink_idle = 54;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full unlock across the time wrap, then already unlocked
        probe_want(32'hFFFF_FFFF, 16'd1111, 32'hFFFF_FFFC, 1'b0, OUT_NEW, 3'd1);
        probe_want(32'hFFFF_FFFF, 16'd11, 32'hFFFF_FFFE, 1'b0, OUT_ADVANCED, 3'd2);
        probe_want(32'hFFFF_FFFF, 16'd2222, 32'h0000_0003, 1'b0, OUT_ADVANCED, 3'd3);
        probe_want(32'hFFFF_FFFF, 16'd222, 32'h0000_0003, 1'b0, OUT_ADVANCED, 3'd4);
        probe_want(32'hFFFF_FFFF, 16'd22, 32'h0000_0008, 1'b1, OUT_UNLOCKED, 3'd0);
        probe_want(32'hFFFF_FFFF, 16'd0, 32'h1234_5678, 1'b1, OUT_ALREADY, 3'd0);
        // new entry off sequence, restart after a gap, wrong port, timeout then wrong port
        probe_want(32'h0000_0000, 16'hFFFF, 32'd0, 1'b0, OUT_NEW, 3'd0);
        probe_want(32'h0000_0000, 16'd1111, 32'd6, 1'b0, OUT_ADVANCED, 3'd1);
        probe_want(32'h0000_0000, 16'd11, 32'd11, 1'b0, OUT_ADVANCED, 3'd2);
        probe_want(32'h0000_0000, 16'd0, 32'd12, 1'b0, OUT_WRONG, 3'd0);
        probe_want(32'h0000_0000, 16'd1111, 32'd16, 1'b0, OUT_ADVANCED, 3'd1);
        probe_want(32'h0000_0000, 16'd11, 32'd22, 1'b0, OUT_WRONG, 3'd0);
        // repeated first knock, gap at the limit across the wrap, then just over it
        probe(32'h8000_0000, 16'd0, 32'h8000_0000);
        probe(32'h8000_0000, 16'd1111, 32'h8000_0005);
        probe(32'h8000_0000, 16'd1111, 32'h8000_0006);
        probe(32'h7FFF_FFFF, 16'd1111, 32'hFFFF_FFFF);
        probe(32'h7FFF_FFFF, 16'd11, 32'h0000_0004);
        probe(32'h7FFF_FFFF, 16'd2222, 32'h0000_000A);
        probe(32'h7FFF_FFFF, 16'd1111, 32'h0000_000A);
        probe(32'h7FFF_FFFF, 16'd11, 32'h0000_000A);
        probe(32'h7FFF_FFFF, 16'd2222, 32'h0000_000F);
        probe(32'h7FFF_FFFF, 16'd222, 32'h0000_0014);
        probe(32'h7FFF_FFFF, 16'd22, 32'h0000_0019);
        foreach (probes[i])
            send_attempt(probes[i].word, probes[i].typed, probes[i].want);
        await_verdicts();

        // random ports, zero timeout
        for (int i = 0; i < KNOCK_LEN; i++)
            c.knock_port[i] = $urandom_range(0, 65535);
        c.knock_timeout = 16'd0;
        load_settings(c);
        run_random(PHASE_LEN, 0, 0);
        await_verdicts();

        // extreme ports with repeats, largest timeout
        src_idle  = 54;
        sink_idle = 17;
        c.knock_port[0] = 16'h0000;
        c.knock_port[1] = 16'hFFFF;
        c.knock_port[2] = 16'hFFFF;
        c.knock_port[3] = 16'h0000;
        c.knock_port[4] = 16'hFFFF;
        c.knock_timeout = 16'hFFFF;
        load_settings(c);
        run_random(PHASE_LEN, POOL_SLICE, 0);
        await_verdicts();

        // random ports, short timeout, fresh addresses fill the table
        src_idle  = 0;
        sink_idle = 0;
        for (int i = 0; i < KNOCK_LEN; i++)
            c.knock_port[i] = $urandom_range(0, 65535);
        c.knock_timeout = $urandom_range(1, 30);
        load_settings(c);
        run_random(PHASE_LEN, 2 * POOL_SLICE, 5);
        await_verdicts();

        repeat (80) @(posedge clk);
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
